// ----- sv/lav_pkg.sv -----
package lav_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned QuotW  = DataW + 2;
  localparam int unsigned SqrtW  = DataW + 1;
  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [ProdW-1:0] wide_t;

  // one normalised vector item: three signs and three magnitudes
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][DataW:0]   mag;
  } nvec_t;

endpackage

// ----- sv/look_at_view_matrix.sv -----
// right-handed look-at view matrix, signed q16.16
// start with busy low takes one word: eye, front and up hint vectors
// result word: three matrix rows (axis x,y,z and offset) on the output
// ports for one cycle, marked by valid_o; the receiver cannot hold it off
// busy is tied low: a new word can enter in every cycle
// pipeline: negate, normalise back (pre-shift, squares, 33 sqrt bit
// stages, 34 divide bit stages), cross up x back, normalise right,
// cross back x right with truncate, then dot products for the offsets
// the path: two normalise passes, two cross units and the offset stage;
// throughput one word per cycle
// the sqrt and divide bit stages set the depth
// reset clears only the valid bits; words in flight are dropped
// zero front gives zero axes; up parallel to front zeroes right and camup; no fault
module look_at_view_matrix import lav_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  word_t eye_x_i, eye_y_i, eye_z_i,
  input  word_t front_x_i, front_y_i, front_z_i,
  input  word_t upward_x_i, upward_y_i, upward_z_i,
  output logic  valid_o,
  output word_t right_x_o, right_y_o, right_z_o, right_offset_o,
  output word_t camup_x_o, camup_y_o, camup_z_o, camup_offset_o,
  output word_t back_x_o, back_y_o, back_z_o, back_offset_o
);

  localparam int unsigned W3 = 3 * DataW;

  assign busy = 1'b0;

  // first normalise: back = norm(-front), side carries eye and up
  wide_t [2:0] nf;
  assign nf[0] = -wide_t'(front_x_i);
  assign nf[1] = -wide_t'(front_y_i);
  assign nf[2] = -wide_t'(front_z_i);

  logic        v1;
  word_t [2:0] back1;
  logic [2*W3-1:0] h1;
  lav_norm #(.SideW(2*W3)) u_norm_back (
    .clk_i, .rst_ni, .valid_i(start),
    .vec_i(nf),
    .side_i({eye_z_i, eye_y_i, eye_x_i, upward_z_i, upward_y_i, upward_x_i}),
    .valid_o(v1), .unit_o(back1), .side_o(h1)
  );

  // up x back, side carries eye and back
  logic        v2;
  wide_t [2:0] cr;
  logic [2*W3-1:0] h2;
  lav_cross #(.SideW(2*W3)) u_cross_right (
    .clk_i, .rst_ni, .valid_i(v1),
    .a_i(h1[W3-1:0]), .b_i(back1),
    .side_i({h1[2*W3-1:W3], back1}),
    .valid_o(v2), .cross_o(cr), .side_o(h2)
  );

  logic        v3;
  word_t [2:0] right3;
  logic [2*W3-1:0] h3;
  lav_norm #(.SideW(2*W3)) u_norm_right (
    .clk_i, .rst_ni, .valid_i(v2),
    .vec_i(cr), .side_i(h2),
    .valid_o(v3), .unit_o(right3), .side_o(h3)
  );

  // back x right, side carries eye, back and right
  logic        v4;
  wide_t [2:0] cu;
  logic [3*W3-1:0] h4;
  lav_cross #(.SideW(3*W3)) u_cross_up (
    .clk_i, .rst_ni, .valid_i(v3),
    .a_i(h3[W3-1:0]), .b_i(right3),
    .side_i({h3, right3}),
    .valid_o(v4), .cross_o(cu), .side_o(h4)
  );

  word_t [2:0] camup4;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      camup4[i] = cu[i][ProdW-1] ? -word_t'((-cu[i]) >> FracW) : word_t'(cu[i] >> FracW);
    end
  end

  // offsets: products and result registered, axes delayed alongside
  logic            v5_q, v6_q;
  word_t [2:0]     eye4;
  logic [3*W3-1:0] ax5_q, ax6_q;
  assign eye4 = h4[3*W3-1:2*W3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v5_q <= v4;
      v6_q <= v5_q;
    end
  end
  always_ff @(posedge clk_i) begin
    ax5_q <= {h4[2*W3-1:0], camup4};
    ax6_q <= ax5_q;
  end

  word_t [2:0] off;
  lav_offset u_off_right (.clk_i, .axis_i(h4[W3-1:0]), .eye_i(eye4), .offset_o(off[0]));
  lav_offset u_off_camup (.clk_i, .axis_i(camup4), .eye_i(eye4), .offset_o(off[1]));
  lav_offset u_off_back  (.clk_i, .axis_i(h4[2*W3-1:W3]), .eye_i(eye4), .offset_o(off[2]));

  // ax6_q layout: back (top), right, camup (bottom)
  assign valid_o        = v6_q;
  assign camup_x_o      = ax6_q[DataW-1:0];
  assign camup_y_o      = ax6_q[2*DataW-1:DataW];
  assign camup_z_o      = ax6_q[3*DataW-1:2*DataW];
  assign right_x_o      = ax6_q[4*DataW-1:3*DataW];
  assign right_y_o      = ax6_q[5*DataW-1:4*DataW];
  assign right_z_o      = ax6_q[6*DataW-1:5*DataW];
  assign back_x_o       = ax6_q[7*DataW-1:6*DataW];
  assign back_y_o       = ax6_q[8*DataW-1:7*DataW];
  assign back_z_o       = ax6_q[9*DataW-1:8*DataW];
  assign right_offset_o = off[0];
  assign camup_offset_o = off[1];
  assign back_offset_o  = off[2];

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni) v4 |=> ##1 valid_o)
    else $error("offset stage lost a word");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && back_x_o == '0 && back_y_o == '0 && back_z_o == '0) |-> (right_x_o == '0))
    else $error("zero back with non-zero right");

endmodule

// ----- sv/lav_norm.sv -----
// pipelined vector normalise: pre-shift, squares, sqrt by bit stages, divide by bit stages
module lav_norm import lav_pkg::*; #(
  parameter int unsigned SideW = 3 * DataW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  wide_t [2:0]           vec_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output word_t [2:0]           unit_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned MagW  = DataW + 1;
  localparam int unsigned SqW   = 2 * MagW;
  localparam int unsigned SqrtN = MagW;
  localparam int unsigned DivN  = QuotW;
  localparam int unsigned NumW  = MagW + FracW;
  localparam int unsigned LatN  = 3 + SqrtN + DivN;

  // stage a: magnitudes and shift
  logic                va_q;
  logic [2:0]          sa_q;
  logic [2:0][ProdW-1:0] ma_q;
  logic [SideW-1:0]    ha_q;
  logic [6:0]          sh_q;

  logic [ProdW-1:0] mx_d;
  logic [2:0][ProdW-1:0] m_d;
  logic [6:0] sh_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i] = vec_i[i][ProdW-1] ? ProdW'(-vec_i[i]) : ProdW'(vec_i[i]);
    end
    mx_d = m_d[0] | m_d[1] | m_d[2];
    sh_d = '0;
    for (int k = 0; k < ProdW - DataW; k++) begin
      if (mx_d[DataW + k]) sh_d = 7'(k + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sa_q[i] <= vec_i[i][ProdW-1];
    end
    ma_q <= m_d;
    ha_q <= side_i;
    sh_q <= sh_d;
  end

  // the or-estimate can be one short; fix by one more shift when needed
  logic [2:0][ProdW-1:0] mb_d;
  logic [ProdW-1:0] mxb;
  always_comb begin
    for (int i = 0; i < 3; i++) mb_d[i] = ma_q[i] >> sh_q;
    mxb = mb_d[0];
    if (mb_d[1] > mxb) mxb = mb_d[1];
    if (mb_d[2] > mxb) mxb = mb_d[2];
    if (mxb > (ProdW'(1) << (DataW - 1))) begin
      for (int i = 0; i < 3; i++) mb_d[i] = mb_d[i] >> 1;
    end
  end

  logic                vb_q;
  logic [2:0]          sb_q;
  logic [2:0][MagW-1:0] mb_q;
  logic [SideW-1:0]    hb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    sb_q <= sa_q;
    for (int i = 0; i < 3; i++) mb_q[i] <= MagW'(mb_d[i]);
    hb_q <= ha_q;
  end

  // stage c: squares (each multiplier then registered)
  logic                vc_q;
  logic [2:0]          sc_q;
  logic [2:0][MagW-1:0] mc_q;
  logic [2:0][SqW-1:0] sq_q;
  logic [SideW-1:0]    hc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    sc_q <= sb_q;
    mc_q <= mb_q;
    hc_q <= hb_q;
    for (int i = 0; i < 3; i++) sq_q[i] <= SqW'(mb_q[i]) * SqW'(mb_q[i]);
  end

  // sqrt pipe, one result bit a stage
  logic [SqrtN:0]                vs_q;
  logic [SqrtN:0][2:0]           ss_q;
  logic [SqrtN:0][2:0][MagW-1:0] ms_q;
  logic [SqrtN:0][SqW-1:0]       rem_q;
  logic [SqrtN:0][SqW-1:0]       x_q;
  logic [SqrtN:0][SqrtW:0]       root_q;
  logic [SqrtN:0][SideW-1:0]     hs_q;

  always_comb begin
    vs_q[0]   = vc_q;
    ss_q[0]   = sc_q;
    ms_q[0]   = mc_q;
    x_q[0]    = sq_q[0] + sq_q[1] + sq_q[2];
    rem_q[0]  = '0;
    root_q[0] = '0;
    hs_q[0]   = hc_q;
  end

  for (genvar g = 0; g < SqrtN; g++) begin : g_sqrt
    logic [SqW-1:0] r2, trial;
    logic [SqrtW:0] rt;
    always_comb begin
      r2    = (rem_q[g] << 2) | SqW'(x_q[g][SqW-1 -: 2]);
      trial = (SqW'(root_q[g]) << 2) | SqW'(1);
      rt    = root_q[g] << 1;
      if (r2 >= trial) begin
        r2 = r2 - trial;
        rt = rt | (SqrtW+1)'(1);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vs_q[g+1] <= 1'b0;
      else vs_q[g+1] <= vs_q[g];
    end
    always_ff @(posedge clk_i) begin
      ss_q[g+1]   <= ss_q[g];
      ms_q[g+1]   <= ms_q[g];
      hs_q[g+1]   <= hs_q[g];
      x_q[g+1]    <= x_q[g] << 2;
      rem_q[g+1]  <= r2;
      root_q[g+1] <= rt;
    end
  end

  // divide pipe, three restoring dividers in lockstep
  logic [DivN:0]                    vd_q;
  logic [DivN:0][2:0]               sd_q;
  logic [DivN:0][SqrtW:0]           den_q;
  logic [DivN:0][2:0][NumW-1:0]     num_q;
  logic [DivN:0][2:0][SqrtW+1:0]    rm_q;
  logic [DivN:0][2:0][QuotW-1:0]    qt_q;
  logic [DivN:0][SideW-1:0]         hd_q;

  // numerator is mag << 16: its top bits preload the remainder,
  // the low DivN bits are fed one a stage
  always_comb begin
    vd_q[0]  = vs_q[SqrtN];
    sd_q[0]  = ss_q[SqrtN];
    den_q[0] = root_q[SqrtN];
    hd_q[0]  = hs_q[SqrtN];
    for (int i = 0; i < 3; i++) begin
      num_q[0][i] = NumW'(ms_q[SqrtN][i]) << (NumW - DivN + FracW);
      rm_q[0][i]  = (SqrtW+2)'(ms_q[SqrtN][i] >> (DivN - FracW));
      qt_q[0][i]  = '0;
    end
  end

  for (genvar g = 0; g < DivN; g++) begin : g_div
    logic [2:0][SqrtW+1:0] rn;
    logic [2:0][QuotW-1:0] qn;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rn[i] = (rm_q[g][i] << 1) | (SqrtW+2)'(num_q[g][i][NumW-1]);
        qn[i] = qt_q[g][i] << 1;
        if (rn[i] >= (SqrtW+2)'(den_q[g])) begin
          rn[i] = rn[i] - (SqrtW+2)'(den_q[g]);
          qn[i] = qn[i] | QuotW'(1);
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[g+1] <= 1'b0;
      else vd_q[g+1] <= vd_q[g];
    end
    always_ff @(posedge clk_i) begin
      sd_q[g+1]  <= sd_q[g];
      den_q[g+1] <= den_q[g];
      hd_q[g+1]  <= hd_q[g];
      for (int i = 0; i < 3; i++) begin
        num_q[g+1][i] <= num_q[g][i] << 1;
        rm_q[g+1][i]  <= rn[i];
        qt_q[g+1][i]  <= qn[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (den_q[DivN] == '0) unit_o[i] = '0;
      else if (sd_q[DivN][i]) unit_o[i] = -word_t'(qt_q[DivN][i][DataW-1:0]);
      else unit_o[i] = word_t'(qt_q[DivN][i][DataW-1:0]);
    end
  end
  assign valid_o = vd_q[DivN];
  assign side_o  = hd_q[DivN];

  // the x unit component never exceeds one
  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && den_q[DivN] != '0) |-> (qt_q[DivN][0] <= QuotW'(1 << FracW)))
    else $error("unit x above one");
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && den_q[DivN] == '0) |-> (unit_o[1] == '0))
    else $error("zero length gives non-zero unit");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(LatN) valid_o)
    else $error("norm pipe lost a word");

endmodule

// ----- sv/lav_cross.sv -----
// registered cross product a x b, full q32.32 result
module lav_cross import lav_pkg::*; #(
  parameter int unsigned SideW = 3 * DataW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  word_t [2:0]      a_i,
  input  word_t [2:0]      b_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output wide_t [2:0]      cross_o,
  output logic [SideW-1:0] side_o
);

  logic             v1_q, v2_q;
  wide_t [5:0]      p_q;
  logic [SideW-1:0] h1_q, h2_q;
  wide_t [2:0]      c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= wide_t'(a_i[1]) * wide_t'(b_i[2]);
    p_q[1] <= wide_t'(a_i[2]) * wide_t'(b_i[1]);
    p_q[2] <= wide_t'(a_i[2]) * wide_t'(b_i[0]);
    p_q[3] <= wide_t'(a_i[0]) * wide_t'(b_i[2]);
    p_q[4] <= wide_t'(a_i[0]) * wide_t'(b_i[1]);
    p_q[5] <= wide_t'(a_i[1]) * wide_t'(b_i[0]);
    h1_q   <= side_i;
    c_q[0] <= p_q[0] - p_q[1];
    c_q[1] <= p_q[2] - p_q[3];
    c_q[2] <= p_q[4] - p_q[5];
    h2_q   <= h1_q;
  end

  assign valid_o = v2_q;
  assign cross_o = c_q;
  assign side_o  = h2_q;

endmodule

// ----- sv/lav_offset.sv -----
// registered dot product with the eye, negated, truncated and saturated
module lav_offset import lav_pkg::*; (
  input  logic        clk_i,
  input  word_t [2:0] axis_i,
  input  word_t [2:0] eye_i,
  output word_t       offset_o
);

  wide_t [2:0] p_q;
  logic signed [ProdW+1:0] s;
  logic [ProdW+1:0] m;
  logic signed [ProdW+1:0] t;
  word_t o_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) p_q[i] <= wide_t'(axis_i[i]) * wide_t'(eye_i[i]);
  end

  always_comb begin
    s = -((ProdW+2)'(p_q[0]) + (ProdW+2)'(p_q[1]) + (ProdW+2)'(p_q[2]));
    m = s[ProdW+1] ? (ProdW+2)'(-s) : (ProdW+2)'(s);
    t = s[ProdW+1] ? -$signed(m >> FracW) : $signed(m >> FracW);
  end

  always_ff @(posedge clk_i) begin
    if (t > (ProdW+2)'(SatMax)) o_q <= SatMax;
    else if (t < (ProdW+2)'(SatMin)) o_q <= SatMin;
    else o_q <= word_t'(t);
  end

  assign offset_o = o_q;

endmodule

// ----- dv/look_at_view_matrix_tb.sv -----
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
  import lav_pkg::*;

  typedef longint vec3_t [3];

  // one camera set-up: eye, front and up hint
  typedef struct {
    word_t eye [3];
    word_t front [3];
    word_t upward [3];
  } camera_t;

  // three matrix rows, each axis x,y,z then offset
  typedef struct {
    word_t row [3][4];
  } view_rows_t;

  localparam int unsigned IdleMax   = 17;
  localparam int unsigned Latency   = 200;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandWords = 1550;

  logic  clk_i, rst_ni;
  logic  start;
  logic  busy;
  word_t eye_x_i, eye_y_i, eye_z_i;
  word_t front_x_i, front_y_i, front_z_i;
  word_t upward_x_i, upward_y_i, upward_z_i;
  logic  valid_o;
  word_t right_x_o, right_y_o, right_z_o, right_offset_o;
  word_t camup_x_o, camup_y_o, camup_z_o, camup_offset_o;
  word_t back_x_o, back_y_o, back_z_o, back_offset_o;

  look_at_view_matrix uut (.*);

  camera_t    pending_cams [$];
  view_rows_t expected_rows [$];
  camera_t    cur_cam;

  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned saturated = 0;
  int unsigned degenerate = 0;
  int unsigned idle_left = 0;
  int unsigned stall_cycles = 0;
  bit          stimulus_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // fixed-point view matrix predictor
  // ---------------------------------------------------------------

  // exact integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // drop 16 fraction bits of the magnitude, sign put back
  function automatic longint drop_frac(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    return (v < 0) ? -longint'(m >> FracW) : longint'(m >> FracW);
  endfunction

  function automatic vec3_t unit_vec(input vec3_t v);
    longint unsigned m [3];
    longint unsigned mx, len;
    vec3_t u;
    for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    // pre-shift so the squares cannot overflow
    while (mx > 64'h8000_0000) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      u[i] = (len == 0) ? 0 : longint'((m[i] << FracW) / len);
      if (v[i] < 0) u[i] = -u[i];
    end
    return u;
  endfunction

  function automatic vec3_t cross_vec(input vec3_t a, input vec3_t b);
    vec3_t c;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    return c;
  endfunction

  // negated dot with the eye, truncated then clamped to 32 bits
  function automatic word_t eye_offset(input vec3_t a, input vec3_t e);
    longint s;
    s = drop_frac(-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]));
    if (s > longint'(SatMax)) s = longint'(SatMax);
    if (s < longint'(SatMin)) s = longint'(SatMin);
    return word_t'(s);
  endfunction

  function automatic view_rows_t view_matrix(input camera_t c);
    vec3_t eye, negf, up, back, right, camup, cu;
    vec3_t axes [3];
    view_rows_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i]  = longint'(c.eye[i]);
      negf[i] = -longint'(c.front[i]);
      up[i]   = longint'(c.upward[i]);
    end
    back  = unit_vec(negf);
    right = unit_vec(cross_vec(up, back));
    cu    = cross_vec(back, right);
    for (int i = 0; i < 3; i++) camup[i] = drop_frac(cu[i]);
    axes[0] = right;
    axes[1] = camup;
    axes[2] = back;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) r.row[k][i] = word_t'(axes[k][i]);
      r.row[k][3] = eye_offset(axes[k], eye);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  function automatic word_t any_word();
    return word_t'($urandom);
  endfunction

  // a few whole units either way, random fraction
  function automatic word_t near_word();
    return word_t'($urandom_range(0, 32'h000F_FFFF)) - word_t'(32'h0008_0000);
  endfunction

  function automatic camera_t make_cam(input word_t e0, e1, e2, f0, f1, f2,
                                       input word_t u0, u1, u2);
    camera_t c;
    c.eye    = '{e0, e1, e2};
    c.front  = '{f0, f1, f2};
    c.upward = '{u0, u1, u2};
    return c;
  endfunction

  function automatic camera_t random_cam();
    camera_t c;
    int unsigned kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      c.eye[i]    = (kind < 6) ? near_word() : any_word();
      c.front[i]  = (kind < 6) ? near_word() : any_word();
      c.upward[i] = (kind < 6) ? near_word() : any_word();
    end
    case (kind)
      6: begin
        // up hint a multiple of front: cross product vanishes
        k = $urandom_range(1, 4);
        for (int i = 0; i < 3; i++) begin
          c.front[i]  = near_word();
          c.upward[i] = c.front[i] * word_t'(k);
        end
      end
      7: c.front = '{default: '0};
      8: for (int i = 0; i < 3; i++) c.eye[i] = $urandom_range(0, 1) ? SatMax : SatMin;
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------
  // driver: one word per handshake, random idle gaps between words
  // ---------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    camera_t c;
    if (!rst_ni) begin
      start      <= 1'b0;
      eye_x_i    <= '0; eye_y_i    <= '0; eye_z_i    <= '0;
      front_x_i  <= '0; front_y_i  <= '0; front_z_i  <= '0;
      upward_x_i <= '0; upward_y_i <= '0; upward_z_i <= '0;
      idle_left  <= 0;
    end else begin
      if (start && !busy) begin
        expected_rows.push_back(view_matrix(cur_cam));
        words_in <= words_in + 1;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (pending_cams.size() > 0) begin
          c = pending_cams.pop_front();
          cur_cam    <= c;
          eye_x_i    <= c.eye[0];    eye_y_i    <= c.eye[1];    eye_z_i    <= c.eye[2];
          front_x_i  <= c.front[0];  front_y_i  <= c.front[1];  front_z_i  <= c.front[2];
          upward_x_i <= c.upward[0]; upward_y_i <= c.upward[1]; upward_z_i <= c.upward[2];
          start      <= 1'b1;
          // bursts of back-to-back words alternate with idle stretches
          idle_left  <= (((words_in / 64) % 2) == 1) ? $urandom_range(0, IdleMax) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: the receiver takes every result word as it comes
  // ---------------------------------------------------------------
  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch on word %0d: %s got %h want %h", words_out, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    view_rows_t want;
    word_t got [3][4];
    string names [3][4];
    if (rst_ni && valid_o) begin
      names = '{'{"right_x", "right_y", "right_z", "right_offset"},
                '{"camup_x", "camup_y", "camup_z", "camup_offset"},
                '{"back_x", "back_y", "back_z", "back_offset"}};
      got = '{'{right_x_o, right_y_o, right_z_o, right_offset_o},
              '{camup_x_o, camup_y_o, camup_z_o, camup_offset_o},
              '{back_x_o, back_y_o, back_z_o, back_offset_o}};
      if (expected_rows.size() == 0) begin
        $display("result word %0d arrived with nothing expected", words_out);
        errors++;
      end else begin
        want = expected_rows.pop_front();
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 4; i++)
            if (got[k][i] !== want.row[k][i])
              report_mismatch(names[k][i], got[k][i], want.row[k][i]);
        for (int k = 0; k < 3; k++)
          if (want.row[k][3] == SatMax || want.row[k][3] == SatMin) saturated++;
        if (want.row[0][0] == 0 && want.row[0][1] == 0 && want.row[0][2] == 0)
          degenerate++;
      end
      words_out++;
    end
  end

  // watchdog: too long without any word moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) stall_cycles <= 0;
      else if (!stimulus_done || expected_rows.size() > 0) stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", stall_cycles);
        $display("** look_at_view_matrix: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    word_t one;
    one = word_t'(32'h0001_0000);
    rst_ni = 1'b0;

    // directed: plain camera, degenerate vectors and field extremes
    pending_cams.push_back(make_cam(0, 0, 0, 0, 0, -one, 0, one, 0));
    pending_cams.push_back(make_cam(one, 2 * one, 3 * one, 0, 0, -one, 0, one, 0));
    pending_cams.push_back(make_cam(0, 0, 0, 0, 0, 0, 0, one, 0));
    pending_cams.push_back(make_cam(one, one, one, 0, 0, 0, 0, 0, 0));
    pending_cams.push_back(make_cam(one, 0, 0, 0, one, 0, 0, 3 * one, 0));
    pending_cams.push_back(make_cam(0, one, 0, one, 0, 0, 0, 0, 0));
    pending_cams.push_back(make_cam(0, 0, 0, -one, -one, -one, -one, -one, -one));
    pending_cams.push_back(make_cam(SatMax, SatMax, SatMax, one, 0, 0, 0, one, 0));
    pending_cams.push_back(make_cam(SatMin, SatMin, SatMin, one, 0, 0, 0, one, 0));
    pending_cams.push_back(make_cam(SatMax, SatMin, SatMax, 0, 0, SatMin, 0, SatMax, 0));
    pending_cams.push_back(make_cam(SatMin, SatMax, SatMin, SatMin, SatMin, SatMin,
                                    SatMax, SatMin, SatMax));
    pending_cams.push_back(make_cam(SatMax, SatMax, SatMax, SatMax, SatMax, SatMax,
                                    SatMin, SatMin, SatMin));
    pending_cams.push_back(make_cam(-1, -1, -1, 1, 1, 1, -1, 1, -1));
    pending_cams.push_back(make_cam(1, 0, -1, 1, 0, 0, 0, 1, 0));
    pending_cams.push_back(make_cam(0, 0, 0, SatMin, 0, 0, SatMin, 0, 0));
    pending_cams.push_back(make_cam(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_cams.push_back(make_cam(SatMax, 0, 0, SatMax, 0, 1, 0, SatMax, 0));
    for (int n = 0; n < RandWords; n++) pending_cams.push_back(random_cam());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cams.size() != 0 || start) @(posedge clk_i);
    stimulus_done = 1;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);

    $display("sent %0d camera set-ups, checked %0d view matrices", words_in, words_out);
    $display("%0d saturated offsets, %0d with a zero right axis", saturated, degenerate);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("** look_at_view_matrix: PASSED **");
    end else begin
      $display("** look_at_view_matrix: FAILED **");
    end
    $finish;
  end

endmodule
